// File: rtl/bht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bht_pkg;

	localparam int HASH_W   = 32;
	localparam int MOD_STEP = 4;
	localparam int MOD_CYC  = HASH_W / MOD_STEP;
	localparam int CNT_W    = 32;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_NO_ROOM  = 2'd2,
		ST_DUP_KEY  = 2'd3
	} result_code_t;

	localparam logic [7:0] REG_PROBING      = 8'd0;
	localparam logic [7:0] REG_BUCKET_COUNT = 8'd1;

	// Action broadcast from the sequencer to the row of bucket cells.
	typedef struct packed {
		logic insert;
		logic remove;
		logic clr;
	} cell_op_t;

	// Report of the cell that holds the probe token; all zero elsewhere.
	typedef struct packed {
		logic hit;
		logic full;
		logic empty;
	} cell_stat_t;

endpackage

`default_nettype wire

// File: rtl/bht_mod.sv
`timescale 1ns / 1ps
`default_nettype none

module bht_mod
	import bht_pkg::*;
#(
	parameter int DIV_W = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [HASH_W-1:0] dividend,
	input  wire logic [DIV_W-1:0]  divisor,
	output logic                   done,
	output logic [DIV_W-1:0]       rem
);

	localparam int CW = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

	logic [HASH_W-1:0] sh_q;
	logic [DIV_W-1:0]  r_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic [DIV_W-1:0]  r_next;

	// Restoring remainder, several dividend bits per cycle.
	always_comb begin
		logic [DIV_W:0]  t;
		logic [DIV_W-1:0] r;
		r = r_q;
		for (int k = 0; k < MOD_STEP; k++) begin
			t = {r, sh_q[HASH_W-1-k]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[DIV_W-1:0];
		end
		r_next = r;
	end

	assign done = run_q && (cnt_q == CW'(MOD_CYC - 1));
	assign rem  = r_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sh_q <= dividend;
			r_q  <= '0;
		end else if (run_q) begin
			sh_q <= sh_q << MOD_STEP;
			r_q  <= r_next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bht_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bht_cell
	import bht_pkg::*;
#(
	parameter int SLOTS = 4,
	parameter int KW    = 64,
	parameter int VW    = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tok_load,
	input  wire logic          tok_home,
	input  wire logic          tok_adv,
	input  wire logic          tok_prev,
	output logic               tok,
	input  wire logic [KW-1:0] key,
	input  wire logic [VW-1:0] data,
	input  wire cell_op_t      op,
	output cell_stat_t         stat,
	output logic [VW-1:0]      value
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic              token_q;
	logic [SLOTS-1:0]  valid_q;
	logic [KW-1:0]     key_q [SLOTS];
	logic [VW-1:0]     val_q [SLOTS];
	logic              hit;
	logic [SW-1:0]     hit_slot;
	logic [SW-1:0]     free_slot;

	always_comb begin
		hit       = 1'b0;
		hit_slot  = '0;
		free_slot = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (valid_q[s] && key_q[s] == key) begin
				hit      = 1'b1;
				hit_slot = SW'(s);
			end
			if (!valid_q[s]) begin
				free_slot = SW'(s);
			end
		end
	end

	assign tok        = token_q;
	assign stat.hit   = token_q & hit;
	assign stat.full  = token_q & (&valid_q);
	assign stat.empty = token_q & ~(|valid_q);
	assign value      = token_q ? val_q[hit_slot] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
			valid_q <= '0;
		end else begin
			if (tok_load) begin
				token_q <= tok_home;
			end else if (tok_adv) begin
				token_q <= tok_prev;
			end
			if (op.clr) begin
				valid_q <= '0;
			end else if (token_q && op.insert) begin
				valid_q[free_slot] <= 1'b1;
			end else if (token_q && op.remove) begin
				valid_q[hit_slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (token_q && op.insert) begin
			key_q[free_slot] <= key;
			val_q[free_slot] <= data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bucketed_hash_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// The home bucket is the hash modulo the bucket count in use, from the remainder unit; then a
// load state hands the probe token to it. The result strobe is registered after the last of the k
// buckets visited (1 to the bucket count in use); a clear gives its result from the load state.
// Throughput: one word at a time; a new start is taken in the cycle the result strobe is high.
// Reset clears every entry's valid bit and the counters, and resets the configuration registers, at once; no sweep.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module bucketed_hash_table_top
	import bht_pkg::*;
#(
	parameter int NUM_BUCKETS  = 16,
	parameter int BUCKET_SLOTS = 4,
	parameter int KEY_WIDTH    = 64,
	parameter int VALUE_WIDTH  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [63:0] key,
	input  wire logic [31:0] hash_value,
	input  wire logic [31:0] data_in,
	output logic             done,
	output logic [1:0]       status,
	output logic             found,
	output logic [31:0]      data_out,
	output logic [3:0]       bucket_used,
	output logic [6:0]       node_total,
	output logic [31:0]      collision_total,
	output logic [31:0]      add_fail_total,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [4:0]  cfg_data
);

	localparam int BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int NBW    = $clog2(NUM_BUCKETS + 1);
	localparam int TOTAL  = NUM_BUCKETS * BUCKET_SLOTS;
	localparam int NODE_W = $clog2(TOTAL + 1);

	typedef enum logic [1:0] {S_IDLE, S_MOD, S_LOAD, S_SCAN} state_t;

	// Configuration registers, always ready; the user writes only while idle (not enforced).
	logic             probing_q;
	logic [4:0]       bucket_count_q;

	// Item held for the whole operation.
	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] data_q;
	logic                   probe_q;
	logic [NBW-1:0]         nb_q;
	logic [BW-1:0]          home_q;
	logic [BW-1:0]          cur_q;
	logic [NBW-1:0]         steps_q;

	logic [NODE_W-1:0] nodes_q;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  fail_q;

	logic [NBW-1:0] nb_eff;
	logic           accept;
	logic           mod_done;
	logic [NBW-1:0] mod_rem;

	logic [NUM_BUCKETS-1:0]  tok;
	logic [NUM_BUCKETS-1:0]  tok_prev;
	logic [NUM_BUCKETS-1:0]  is_last;
	cell_stat_t              stat_c [NUM_BUCKETS];
	logic [VALUE_WIDTH-1:0]  val_c  [NUM_BUCKETS];
	cell_stat_t              stat_all;
	logic [VALUE_WIDTH-1:0]  val_all;

	cell_op_t       op;
	logic           tok_load;
	logic           adv;
	logic           emit;
	result_code_t   r_status;
	logic           r_found;
	logic [31:0]    r_dout;
	logic [BW-1:0]  r_bucket;
	logic           inc_node;
	logic           dec_node;
	logic           inc_col;
	logic           inc_fail;
	logic           last_step;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// A bucket count of zero acts as one, and one above the table size acts as the table size.
	always_comb begin
		if (bucket_count_q == 5'd0) begin
			nb_eff = NBW'(1);
		end else if (int'(bucket_count_q) > NUM_BUCKETS) begin
			nb_eff = NBW'(NUM_BUCKETS);
		end else begin
			nb_eff = NBW'(bucket_count_q);
		end
	end

	bht_mod #(.DIV_W(NBW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept),
		.dividend (hash_value),
		.divisor  (nb_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// The probe token walks the chain one bucket per cycle. The last bucket in use hands it
	// back to bucket zero, so buckets beyond the count in use are never visited.
	always_comb begin
		logic wrap;
		wrap = 1'b0;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			is_last[i] = (int'(nb_q) == i + 1);
			wrap       = wrap | (tok[i] & is_last[i]);
		end
		tok_prev[0] = wrap;
		for (int i = 1; i < NUM_BUCKETS; i++) begin
			tok_prev[i] = tok[i-1] & ~is_last[i-1];
		end
	end

	for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_cell
		bht_cell #(
			.SLOTS (BUCKET_SLOTS),
			.KW    (KEY_WIDTH),
			.VW    (VALUE_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_load (tok_load),
			.tok_home (cur_q == BW'(g)),
			.tok_adv  (adv),
			.tok_prev (tok_prev[g]),
			.tok      (tok[g]),
			.key      (key_q),
			.data     (data_q),
			.op       (op),
			.stat     (stat_c[g]),
			.value    (val_c[g])
		);
	end

	// Only the cell holding the token reports, so an OR gathers its report.
	always_comb begin
		stat_all = '0;
		val_all  = '0;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			stat_all = stat_all | stat_c[i];
			val_all  = val_all | val_c[i];
		end
	end

	assign last_step = ((steps_q + NBW'(1)) == nb_q);

	// Decision for the bucket under the token in this cycle.
	always_comb begin
		op       = '0;
		tok_load = 1'b0;
		adv      = 1'b0;
		emit     = 1'b0;
		r_status = ST_OK;
		r_found  = 1'b0;
		r_dout   = '0;
		r_bucket = home_q;
		inc_node = 1'b0;
		dec_node = 1'b0;
		inc_col  = 1'b0;
		inc_fail = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_MOD: begin
			end
			S_LOAD: begin
				tok_load = 1'b1;
				if (cmd_q == CMD_CLEAR) begin
					op.clr   = 1'b1;
					emit     = 1'b1;
					r_bucket = '0;
				end
			end
			S_SCAN: begin
				if (cmd_q == CMD_ADD) begin
					if (!stat_all.full) begin
						emit     = 1'b1;
						r_bucket = cur_q;
						if (stat_all.hit) begin
							r_status = ST_DUP_KEY;
						end else begin
							op.insert = 1'b1;
							inc_node  = 1'b1;
							inc_col   = !stat_all.empty;
						end
					end else if (!probe_q || last_step) begin
						emit     = 1'b1;
						r_status = ST_NO_ROOM;
						inc_fail = 1'b1;
					end else begin
						adv = 1'b1;
					end
				end else begin
					if (stat_all.hit) begin
						emit     = 1'b1;
						r_found  = 1'b1;
						r_bucket = cur_q;
						if (cmd_q == CMD_REMOVE) begin
							op.remove = 1'b1;
							dec_node  = 1'b1;
						end else begin
							r_dout = 32'(val_all);
						end
					end else if (!probe_q || last_step) begin
						emit     = 1'b1;
						r_status = ST_NOT_FOUND;
					end else begin
						adv = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probing_q      <= 1'b0;
			bucket_count_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PROBING:      probing_q      <= cfg_data[0];
				REG_BUCKET_COUNT: bucket_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			nodes_q         <= '0;
			col_q           <= '0;
			fail_q          <= '0;
			done            <= 1'b0;
			cur_q           <= '0;
			home_q          <= '0;
			steps_q         <= '0;
			status          <= ST_OK;
			found           <= 1'b0;
			data_out        <= '0;
			bucket_used     <= '0;
			node_total      <= '0;
			collision_total <= '0;
			add_fail_total  <= '0;
		end else begin
			done <= emit;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						home_q  <= BW'(mod_rem);
						cur_q   <= BW'(mod_rem);
						steps_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= (cmd_q == CMD_CLEAR) ? S_IDLE : S_SCAN;
				end
				S_SCAN: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
					if (adv) begin
						steps_q <= steps_q + NBW'(1);
						cur_q   <= ((NBW'(cur_q) + NBW'(1)) == nb_q) ? '0 : cur_q + BW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (emit) begin
				logic [NODE_W-1:0] n_next;
				logic [CNT_W-1:0]  c_next;
				logic [CNT_W-1:0]  f_next;
				n_next = nodes_q;
				if (op.clr) begin
					n_next = '0;
				end else if (inc_node) begin
					n_next = nodes_q + NODE_W'(1);
				end else if (dec_node && nodes_q != '0) begin
					n_next = nodes_q - NODE_W'(1);
				end
				c_next = (inc_col && col_q != '1) ? col_q + CNT_W'(1) : col_q;
				f_next = (inc_fail && fail_q != '1) ? fail_q + CNT_W'(1) : fail_q;
				nodes_q         <= n_next;
				col_q           <= c_next;
				fail_q          <= f_next;
				status          <= r_status;
				found           <= r_found;
				data_out        <= r_dout;
				bucket_used     <= 4'(r_bucket);
				node_total      <= 7'(n_next);
				collision_total <= c_next;
				add_fail_total  <= f_next;
			end
		end
	end

	// The item and a snapshot of the configuration, taken on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(cmd);
			key_q   <= KEY_WIDTH'(key);
			data_q  <= VALUE_WIDTH'(data_in);
			probe_q <= probing_q;
			nb_q    <= nb_eff;
		end
	end

`ifndef SYNTH
	// While scanning, exactly one bucket cell holds the probe token.
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> $onehot(tok))
		else $error("probe token is not one-hot during a scan");

	// A result strobe is never followed at once by another one.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// An accepted word makes the block busy in the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("block not busy after accepting a word");

	// The entry count never exceeds the table capacity.
	a_nodes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(nodes_q) <= TOTAL)
		else $error("entry count beyond table capacity");
`endif

endmodule

`default_nettype wire

// File: verif/bucketed_hash_table_top_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the bucketed hash table. A scoreboard object keeps a
// shadow copy of the table and predicts the result word of every command
// accepted. Commands are driven on the falling edge and results are sampled on
// the rising edge. The random commands draw keys from a small pool, so that
// adds, hits, duplicates and full buckets all happen often.
module bucketed_hash_table_top_test;
	import bht_pkg::*;

	localparam int NB    = 16;
	localparam int SLOTS = 4;

	// One result word as the table presents it.
	typedef struct {
		result_code_t st;
		logic        hit;
		logic [31:0] value;
		logic [3:0]  bkt;
		logic [6:0]  nodes;
		logic [31:0] colls;
		logic [31:0] refusals;
	} table_result_t;

	int error_count = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
	endtask

	// Shadow of the table, which predicts each result and checks it in order.
	class table_scoreboard;
		logic        probe_on;
		logic [4:0]  bucket_reg;
		logic        slot_valid [NB*SLOTS];
		logic [63:0] slot_key   [NB*SLOTS];
		logic [31:0] slot_value [NB*SLOTS];
		logic [6:0]  nodes;
		logic [31:0] colls;
		logic [31:0] refusals;
		table_result_t pending_results[$];
		int checked = 0;

		function new();
			probe_on   = 1'b0;
			bucket_reg = 5'd16;
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
			nodes    = '0;
			colls    = '0;
			refusals = '0;
		endfunction

		function void write_register(input logic [7:0] idx, input logic [4:0] val);
			if (idx == REG_PROBING)
				probe_on = val[0];
			else if (idx == REG_BUCKET_COUNT)
				bucket_reg = val;
		endfunction

		function int buckets_live();
			if (bucket_reg == 0) return 1;
			if (bucket_reg > NB) return NB;
			return bucket_reg;
		endfunction

		function int slot_with_key(input int b, input logic [63:0] k);
			for (int s = 0; s < SLOTS; s++)
				if (slot_valid[b*SLOTS+s] && slot_key[b*SLOTS+s] == k) return s;
			return -1;
		endfunction

		function int fill_of(input int b);
			int n;
			n = 0;
			for (int s = 0; s < SLOTS; s++)
				if (slot_valid[b*SLOTS+s]) n++;
			return n;
		endfunction

		// Searches from the home bucket, and on through the others if probing is on.
		function bit search(input int home, input int nb, input logic [63:0] k,
				output int bk, output int sl);
			int b;
			int s;
			bk = 0;
			sl = 0;
			for (int step = 0; step < nb; step++) begin
				b = (home + step) % nb;
				s = slot_with_key(b, k);
				if (s >= 0) begin
					bk = b;
					sl = s;
					return 1;
				end
				if (!probe_on) break;
			end
			return 0;
		endfunction

		function void note_command(input cmd_t c, input logic [63:0] k,
				input logic [31:0] h, input logic [31:0] d);
			table_result_t r;
			int nb;
			int home;
			int b;
			int s;
			int c2;
			bit room;
			nb   = buckets_live();
			home = h % nb;
			r.st = ST_OK;
			r.hit = 1'b0;
			r.value = '0;
			r.bkt = home[3:0];
			case (c)
				CMD_LOOKUP: begin
					if (search(home, nb, k, b, s)) begin
						r.hit   = 1'b1;
						r.value = slot_value[b*SLOTS+s];
						r.bkt   = b[3:0];
					end else
						r.st = ST_NOT_FOUND;
				end
				CMD_ADD: begin
					room = 1;
					b = home;
					if (fill_of(home) >= SLOTS) begin
						room = 0;
						if (probe_on) begin
							for (int step = 1; step < nb; step++) begin
								c2 = (home + step) % nb;
								if (fill_of(c2) < SLOTS) begin
									b = c2;
									room = 1;
									break;
								end
							end
						end
					end
					if (!room) begin
						r.st = ST_NO_ROOM;
						if (refusals != 32'hFFFF_FFFF) refusals++;
					end else if (slot_with_key(b, k) >= 0) begin
						r.st  = ST_DUP_KEY;
						r.bkt = b[3:0];
					end else begin
						if (fill_of(b) != 0 && colls != 32'hFFFF_FFFF) colls++;
						for (s = 0; s < SLOTS; s++) begin
							if (!slot_valid[b*SLOTS+s]) begin
								slot_valid[b*SLOTS+s] = 1'b1;
								slot_key[b*SLOTS+s]   = k;
								slot_value[b*SLOTS+s] = d;
								break;
							end
						end
						nodes++;
						r.bkt = b[3:0];
					end
				end
				CMD_REMOVE: begin
					if (search(home, nb, k, b, s)) begin
						slot_valid[b*SLOTS+s] = 1'b0;
						if (nodes > 0) nodes--;
						r.hit = 1'b1;
						r.bkt = b[3:0];
					end else
						r.st = ST_NOT_FOUND;
				end
				default: begin
					foreach (slot_valid[i]) slot_valid[i] = 1'b0;
					nodes = '0;
					r.bkt = '0;
				end
			endcase
			r.nodes    = nodes;
			r.colls    = colls;
			r.refusals = refusals;
			pending_results.push_back(r);
		endfunction

		task check_result(input table_result_t got);
			table_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", 32'd0, 32'd0);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.st !== want.st) report_mismatch("status", got.st, want.st);
			if (got.hit !== want.hit) report_mismatch("found", got.hit, want.hit);
			if (got.value !== want.value) report_mismatch("data_out", got.value, want.value);
			if (got.bkt !== want.bkt) report_mismatch("bucket_used", got.bkt, want.bkt);
			if (got.nodes !== want.nodes) report_mismatch("node_total", got.nodes, want.nodes);
			if (got.colls !== want.colls)
				report_mismatch("collision_total", got.colls, want.colls);
			if (got.refusals !== want.refusals)
				report_mismatch("add_fail_total", got.refusals, want.refusals);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = '0;
	logic [63:0] key = '0;
	logic [31:0] hash_value = '0;
	logic [31:0] data_in = '0;
	logic        done;
	logic [1:0]  status;
	logic        found;
	logic [31:0] data_out;
	logic [3:0]  bucket_used;
	logic [6:0]  node_total;
	logic [31:0] collision_total;
	logic [31:0] add_fail_total;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;

	table_scoreboard tracker = new();

	// Pool of keys: reused keys make hits, duplicates and removals likely.
	logic [63:0] key_pool [16];
	bit          calm_mode = 0;
	int          words_sent = 0;

	always #2 clk = ~clk;

	bucketed_hash_table_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .key(key), .hash_value(hash_value), .data_in(data_in),
		.done(done), .status(status), .found(found), .data_out(data_out),
		.bucket_used(bucket_used), .node_total(node_total),
		.collision_total(collision_total), .add_fail_total(add_fail_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Every strobed result word is checked at the rising edge that takes it.
	always @(posedge clk) begin
		table_result_t got;
		if (arst_n && done) begin
			got.st       = result_code_t'(status);
			got.hit      = found;
			got.value    = data_out;
			got.bkt      = bucket_used;
			got.nodes    = node_total;
			got.colls    = collision_total;
			got.refusals = add_fail_total;
			tracker.check_result(got);
		end
	end

	// Drives one command word and holds it until the table takes it.
	task automatic send_command(input cmd_t c, input logic [63:0] k,
			input logic [31:0] h, input logic [31:0] d);
		int gap;
		if (!calm_mode && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			repeat (gap) @(negedge clk);
		end
		start      = 1'b1;
		cmd        = c;
		key        = k;
		hash_value = h;
		data_in    = d;
		do @(posedge clk); while (busy);
		tracker.note_command(c, k, h, d);
		words_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	// Waits until every result is in, then lets the table settle before a write.
	task automatic drain_table();
		while (tracker.pending_results.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_register(input logic [7:0] idx, input logic [4:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_register(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// A random command: mostly adds and lookups on pooled keys, hashes that
	// fall into a few buckets so they fill up, and now and then a clear.
	task automatic send_random();
		int pick;
		cmd_t c;
		logic [63:0] k;
		logic [31:0] h;
		pick = $urandom_range(0, 99);
		if (pick < 40) c = CMD_ADD;
		else if (pick < 70) c = CMD_LOOKUP;
		else if (pick < 97) c = CMD_REMOVE;
		else c = CMD_CLEAR;
		if ($urandom_range(0, 9) == 0)
			k = {$urandom, $urandom};
		else
			k = key_pool[$urandom_range(0, 15)];
		if ($urandom_range(0, 3) == 0)
			h = $urandom;
		else
			h = k[31:0] ^ {28'd0, 4'($urandom_range(0, 3))};
		send_command(c, k, h, $urandom);
	endtask

	initial begin
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with the reset settings: no probing, sixteen buckets.
		send_command(CMD_LOOKUP, 64'd0, 32'd0, 32'd0);
		send_command(CMD_ADD, 64'd0, 32'd0, 32'hFFFF_FFFF);
		send_command(CMD_ADD, 64'd0, 32'd0, 32'h1234_5678);
		send_command(CMD_ADD, '1, 32'hFFFF_FFFF, 32'd0);
		for (int i = 1; i < 4; i++)
			send_command(CMD_ADD, 64'(i), 32'd16 * i, 32'(i));
		// Home bucket now full: refused even for a key already there.
		send_command(CMD_ADD, 64'd0, 32'd0, 32'd7);
		send_command(CMD_LOOKUP, '1, 32'hFFFF_FFFF, 32'd0);
		send_command(CMD_REMOVE, 64'd2, 32'd0, 32'd0);
		send_command(CMD_REMOVE, 64'd2, 32'd0, 32'd0);
		send_command(CMD_LOOKUP, 64'd3, 32'd5, 32'd0);
		drain_table();

		// Probing on: a full home bucket overflows into its neighbour.
		write_register(REG_PROBING, 5'd1);
		send_command(CMD_ADD, 64'hAA, 32'd0, 32'hA5A5_A5A5);
		send_command(CMD_ADD, 64'h5555_5555_5555_5555, 32'd0, 32'h5A5A_5A5A);
		send_command(CMD_LOOKUP, 64'hAA, 32'd0, 32'd0);
		send_command(CMD_REMOVE, 64'hAA, 32'd0, 32'd0);
		drain_table();

		// A bucket count of zero acts as one; only bucket zero is then used.
		write_register(REG_BUCKET_COUNT, 5'd0);
		for (int i = 0; i < 5; i++)
			send_command(CMD_ADD, 64'(100 + i), 32'(i * 7), 32'(i));
		send_command(CMD_LOOKUP, 64'd3, 32'd9, 32'd0);
		drain_table();
		// Above sixteen acts as sixteen.
		write_register(REG_BUCKET_COUNT, 5'd31);
		send_command(CMD_LOOKUP, 64'd1, 32'd16, 32'd0);
		send_command(CMD_CLEAR, '1, '1, '1);
		drain_table();

		// Random phases, each under its own settings, the extremes among them.
		for (int phase = 0; phase < 8; phase++) begin
			write_register(REG_PROBING, 5'($urandom_range(0, 1)));
			case (phase)
				0: write_register(REG_BUCKET_COUNT, 5'd16);
				1: write_register(REG_BUCKET_COUNT, 5'd1);
				2: write_register(REG_BUCKET_COUNT, 5'd2);
				default: write_register(REG_BUCKET_COUNT, 5'($urandom_range(0, 31)));
			endcase
			calm_mode = (phase == 7);
			for (int n = 0; n < 50; n++) send_random();
			drain_table();
		end

		$display("%0d command words sent, %0d results checked, %0d nodes held at the end.",
			words_sent, tracker.checked, tracker.nodes);
		$display("Covered lookups, adds, removes, clears, probing and bucket counts 0 to 31.");
		if (error_count == 0 && tracker.pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#4ms;
		$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bht_pkg.sv
rtl/bht_mod.sv
rtl/bht_cell.sv
rtl/bucketed_hash_table_top.sv
verif/bucketed_hash_table_top_test.sv
